### sv/fasr_pkg.sv
// Package for the fraction add/subtract/reduce block.
// Holds the controller/datapath command and status types and the fixed result widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fasr_pkg;

	localparam int NUM_OUT_WIDTH = 33;
	localparam int DEN_OUT_WIDTH = 32;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_ZERO    = 2'd1,
		ST_DIVZERO = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		MUL_AD = 2'd0,
		MUL_CB = 2'd1,
		MUL_BD = 2'd2
	} mul_sel_t;

	typedef struct packed {
		logic     capture;
		mul_sel_t mul_sel;
		logic     mul_first;
		logic     mul_park;
		logic     mul_accum;
		logic     check;
		logic     gcd_step;
		logic     div_load;
		logic     div_step;
		logic     load_res;
	} fasr_cmd_t;

	typedef struct packed {
		logic special;
		logic gcd_done;
		logic div_last;
	} fasr_sts_t;

endpackage

`default_nettype wire

### sv/fasr_ctrl.sv
// Controller state machine for the fraction add/subtract/reduce block.
// Sequences multiply, check, binary GCD and division steps; owns the handshakes.
// Depends on fasr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fasr_ctrl
	import fasr_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  wire logic      out_stall,
	output fasr_cmd_t      cmd,
	input  wire fasr_sts_t sts
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_MUL_AD = 8'b0000_0010,
		S_MUL_CB = 8'b0000_0100,
		S_MUL_BD = 8'b0000_1000,
		S_CHECK  = 8'b0001_0000,
		S_GCD    = 8'b0010_0000,
		S_DIV    = 8'b0100_0000,
		S_FINISH = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_MUL_AD;
				end
			end
			S_MUL_AD: begin
				cmd.mul_sel   = MUL_AD;
				cmd.mul_first = 1'b1;
				state_d       = S_MUL_CB;
			end
			S_MUL_CB: begin
				cmd.mul_sel  = MUL_CB;
				cmd.mul_park = 1'b1;
				state_d      = S_MUL_BD;
			end
			S_MUL_BD: begin
				cmd.mul_sel   = MUL_BD;
				cmd.mul_accum = 1'b1;
				state_d       = S_CHECK;
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_d   = sts.special ? S_FINISH : S_GCD;
			end
			S_GCD: begin
				if (sts.gcd_done) begin
					cmd.div_load = 1'b1;
					state_d      = S_DIV;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_res = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_res) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### sv/fasr_dp.sv
// Datapath for the fraction add/subtract/reduce block.
// Shared multiplier, binary GCD unit, dual restoring divider and result register.
// Depends on fasr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fasr_dp
	import fasr_pkg::*;
#(
	parameter int OPERAND_WIDTH = 16
) (
	input  wire logic                            clk,
	input  wire fasr_cmd_t                       cmd,
	output fasr_sts_t                            sts,
	input  wire logic                            operation,
	input  wire logic signed [OPERAND_WIDTH-1:0] first_numerator,
	input  wire logic signed [OPERAND_WIDTH-1:0] first_denominator,
	input  wire logic signed [OPERAND_WIDTH-1:0] second_numerator,
	input  wire logic signed [OPERAND_WIDTH-1:0] second_denominator,
	output logic signed [NUM_OUT_WIDTH-1:0]      result_numerator,
	output logic signed [DEN_OUT_WIDTH-1:0]      result_denominator,
	output logic [1:0]                           result_status
);

	localparam int W   = OPERAND_WIDTH;
	localparam int PW  = 2 * W;
	localparam int NW  = (2 * W + 1 > 64) ? 64 : 2 * W + 1;
	localparam int CW  = $clog2(NW + 1);
	localparam int RNW = (NW > NUM_OUT_WIDTH) ? NW : NUM_OUT_WIDTH;
	localparam int RDW = (NW > DEN_OUT_WIDTH) ? NW : DEN_OUT_WIDTH;

	logic                 op_q;
	logic signed [W-1:0]  fn_q, fd_q, sn_q, sd_q;
	logic signed [W-1:0]  mul_x, mul_y;
	logic signed [PW-1:0] prod_q;
	logic signed [NW-1:0] num_q;
	logic [NW-1:0]        ga_q, gb_q, xn_q, xd_q, rem_n_q, rem_d_q;
	logic                 neg_n_q, neg_d_q;
	logic [CW-1:0]        div_cnt_q;
	status_t              status_q;

	logic                 den_zero, num_zero;
	logic [NW-1:0]        mag_n;
	logic [PW-1:0]        mag_d;
	logic [NW:0]          sh_n, sh_d, diff_n, diff_d;
	logic [RNW-1:0]       qn_ext, rn_full;
	logic [RDW-1:0]       qd_ext, rd_full;

	logic signed [NUM_OUT_WIDTH-1:0] res_num_q;
	logic signed [DEN_OUT_WIDTH-1:0] res_den_q;
	status_t                         res_status_q;

	always_comb begin
		case (cmd.mul_sel)
			MUL_AD: begin
				mul_x = fn_q;
				mul_y = sd_q;
			end
			MUL_CB: begin
				mul_x = sn_q;
				mul_y = fd_q;
			end
			default: begin
				mul_x = fd_q;
				mul_y = sd_q;
			end
		endcase
	end

	assign den_zero = (prod_q == '0);
	assign num_zero = (num_q == '0);
	assign mag_n    = num_q[NW-1] ? (~num_q + 1'b1) : num_q;
	assign mag_d    = prod_q[PW-1] ? (~prod_q + 1'b1) : prod_q;

	assign sh_n   = {rem_n_q, xn_q[NW-1]};
	assign sh_d   = {rem_d_q, xd_q[NW-1]};
	assign diff_n = sh_n - {1'b0, ga_q};
	assign diff_d = sh_d - {1'b0, ga_q};

	assign qn_ext  = RNW'(xn_q);
	assign rn_full = neg_n_q ? (~qn_ext + 1'b1) : qn_ext;
	assign qd_ext  = RDW'(xd_q);
	assign rd_full = neg_d_q ? (~qd_ext + 1'b1) : qd_ext;

	assign sts.special  = den_zero || num_zero;
	assign sts.gcd_done = (ga_q == gb_q);
	assign sts.div_last = (div_cnt_q == CW'(1));

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= operation;
			fn_q <= first_numerator;
			fd_q <= first_denominator;
			sn_q <= second_numerator;
			sd_q <= second_denominator;
		end

		if (cmd.mul_first || cmd.mul_park || cmd.mul_accum) begin
			prod_q <= mul_x * mul_y;
		end
		if (cmd.mul_park) begin
			num_q <= NW'(prod_q);
		end else if (cmd.mul_accum) begin
			num_q <= op_q ? (num_q - NW'(prod_q)) : (num_q + NW'(prod_q));
		end

		if (cmd.check) begin
			status_q <= den_zero ? ST_DIVZERO : (num_zero ? ST_ZERO : ST_OK);
			neg_n_q  <= num_q[NW-1];
			neg_d_q  <= prod_q[PW-1];
			ga_q     <= mag_n;
			gb_q     <= NW'(mag_d);
			xn_q     <= mag_n;
			xd_q     <= NW'(mag_d);
		end else if (cmd.gcd_step) begin
			if (!ga_q[0] && !gb_q[0]) begin
				ga_q <= ga_q >> 1;
				gb_q <= gb_q >> 1;
				xn_q <= xn_q >> 1;
				xd_q <= xd_q >> 1;
			end else if (!ga_q[0]) begin
				ga_q <= ga_q >> 1;
			end else if (!gb_q[0]) begin
				gb_q <= gb_q >> 1;
			end else if (ga_q > gb_q) begin
				ga_q <= ga_q - gb_q;
			end else begin
				gb_q <= gb_q - ga_q;
			end
		end else if (cmd.div_step) begin
			if (!diff_n[NW]) begin
				rem_n_q <= diff_n[NW-1:0];
				xn_q    <= {xn_q[NW-2:0], 1'b1};
			end else begin
				rem_n_q <= sh_n[NW-1:0];
				xn_q    <= {xn_q[NW-2:0], 1'b0};
			end
			if (!diff_d[NW]) begin
				rem_d_q <= diff_d[NW-1:0];
				xd_q    <= {xd_q[NW-2:0], 1'b1};
			end else begin
				rem_d_q <= sh_d[NW-1:0];
				xd_q    <= {xd_q[NW-2:0], 1'b0};
			end
		end

		if (cmd.div_load) begin
			rem_n_q   <= '0;
			rem_d_q   <= '0;
			div_cnt_q <= CW'(NW);
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q - 1'b1;
		end

		if (cmd.load_res) begin
			res_status_q <= status_q;
			case (status_q)
				ST_DIVZERO: begin
					res_num_q <= '0;
					res_den_q <= '0;
				end
				ST_ZERO: begin
					res_num_q <= '0;
					res_den_q <= DEN_OUT_WIDTH'(1);
				end
				default: begin
					res_num_q <= rn_full[NUM_OUT_WIDTH-1:0];
					res_den_q <= rd_full[DEN_OUT_WIDTH-1:0];
				end
			endcase
		end
	end

	assign result_numerator   = res_num_q;
	assign result_denominator = res_den_q;
	assign result_status      = res_status_q;

endmodule

`default_nettype wire

### sv/fraction_add_sub_reduce_top.sv
// Sequence: capture, the AD, CB and BD multiply states, check, binary GCD steps until both
// values match, then the restoring divider steps and the result load; a zero or
// division-by-zero result skips the GCD and divider. A stalled output holds the block in its last state.
// Throughput: one transaction at a time; the next is taken once the result is in the output
// register, set by the bit-serial GCD loop and the one-bit-per-cycle divider.
// Reset: arst_n clears the controller and output valid; datapath registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module fraction_add_sub_reduce_top
	import fasr_pkg::*;
#(
	parameter int OPERAND_WIDTH = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            operation,
	input  wire logic signed [OPERAND_WIDTH-1:0] first_numerator,
	input  wire logic signed [OPERAND_WIDTH-1:0] first_denominator,
	input  wire logic signed [OPERAND_WIDTH-1:0] second_numerator,
	input  wire logic signed [OPERAND_WIDTH-1:0] second_denominator,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic signed [NUM_OUT_WIDTH-1:0]      result_numerator,
	output logic signed [DEN_OUT_WIDTH-1:0]      result_denominator,
	output logic [1:0]                           result_status
);

	fasr_cmd_t cmd;
	fasr_sts_t sts;

	fasr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	fasr_dp #(
		.OPERAND_WIDTH (OPERAND_WIDTH)
	) u_dp (
		.clk                (clk),
		.cmd                (cmd),
		.sts                (sts),
		.operation          (operation),
		.first_numerator    (first_numerator),
		.first_denominator  (first_denominator),
		.second_numerator   (second_numerator),
		.second_denominator (second_denominator),
		.result_numerator   (result_numerator),
		.result_denominator (result_denominator),
		.result_status      (result_status)
	);

endmodule

`default_nettype wire

### tb/fraction_add_sub_reduce_top_tb.sv
// Testbench for fraction_add_sub_reduce_top: adds or subtracts two signed fractions and checks the
// reduced result and status against an in-bench predictor, with random idling and back-pressure.
// Depends on fasr_pkg and fraction_add_sub_reduce_top.
`timescale 1ns / 1ps
`default_nettype none

module fraction_add_sub_reduce_top_tb;
	import fasr_pkg::*;

	localparam int OPERAND_WIDTH = 16;
	localparam logic OP_ADD = 1'b0;
	localparam logic OP_SUB = 1'b1;

	typedef struct {
		logic                            op;
		logic signed [OPERAND_WIDTH-1:0] a;
		logic signed [OPERAND_WIDTH-1:0] b;
		logic signed [OPERAND_WIDTH-1:0] c;
		logic signed [OPERAND_WIDTH-1:0] d;
		bit                              drain_before;
	} fraction_pair_t;

	typedef struct {
		logic signed [NUM_OUT_WIDTH-1:0] num;
		logic signed [DEN_OUT_WIDTH-1:0] den;
		status_t                         status;
	} reduced_fraction_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic operation = 1'b0;
	logic signed [OPERAND_WIDTH-1:0] first_numerator = '0;
	logic signed [OPERAND_WIDTH-1:0] first_denominator = '0;
	logic signed [OPERAND_WIDTH-1:0] second_numerator = '0;
	logic signed [OPERAND_WIDTH-1:0] second_denominator = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [NUM_OUT_WIDTH-1:0] result_numerator;
	logic signed [DEN_OUT_WIDTH-1:0] result_denominator;
	logic [1:0] result_status;

	fraction_pair_t    pending_pairs[$];
	reduced_fraction_t expected_fractions[$];
	logic in_taken = 1'b0;
	int   items_sent = 0;
	int   items_accepted = 0;
	int   total_items = 0;
	int   fractions_seen = 0;
	int   mismatch_count = 0;
	int   hold_left = 0;
	bit   hold_done = 1'b0;

	fraction_add_sub_reduce_top #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.operation         (operation),
		.first_numerator   (first_numerator),
		.first_denominator (first_denominator),
		.second_numerator  (second_numerator),
		.second_denominator(second_denominator),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.result_numerator  (result_numerator),
		.result_denominator(result_denominator),
		.result_status     (result_status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic reduced_fraction_t reduced_sum(input fraction_pair_t p);
		longint a, b, c, d, num, den, mn, md, x, y, t;
		reduced_fraction_t r;
		a = longint'(p.a);
		b = longint'(p.b);
		c = longint'(p.c);
		d = longint'(p.d);
		num = (p.op == OP_SUB) ? a * d - c * b : a * d + c * b;
		den = b * d;
		if (den == 0) begin
			r.num = '0;
			r.den = '0;
			r.status = ST_DIVZERO;
		end else if (num == 0) begin
			r.num = '0;
			r.den = 1;
			r.status = ST_ZERO;
		end else begin
			mn = (num < 0) ? -num : num;
			md = (den < 0) ? -den : den;
			x = mn;
			y = md;
			while (y != 0) begin
				t = x % y;
				x = y;
				y = t;
			end
			r.num = NUM_OUT_WIDTH'((num < 0) ? -(mn / x) : mn / x);
			r.den = DEN_OUT_WIDTH'((den < 0) ? -(md / x) : md / x);
			r.status = ST_OK;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatch_count++;
		$display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
	endtask

	task automatic add_pair(input logic op, input int a, input int b, input int c, input int d);
		fraction_pair_t p;
		p.op = op;
		p.a = OPERAND_WIDTH'(a);
		p.b = OPERAND_WIDTH'(b);
		p.c = OPERAND_WIDTH'(c);
		p.d = OPERAND_WIDTH'(d);
		p.drain_before = 1'b0;
		pending_pairs.push_back(p);
	endtask

	// driver
	always @(negedge clk or negedge arst_n) begin : driver
		fraction_pair_t next_pair;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (pending_pairs.size() == 0 ||
			    (pending_pairs[0].drain_before && expected_fractions.size() != 0) ||
			    (!(items_sent >= 300 && items_sent < 450) && $urandom_range(0, 99) < 11)) begin
				in_valid <= 1'b0;
			end else begin
				next_pair = pending_pairs.pop_front();
				in_valid <= 1'b1;
				operation <= next_pair.op;
				first_numerator <= next_pair.a;
				first_denominator <= next_pair.b;
				second_numerator <= next_pair.c;
				second_denominator <= next_pair.d;
				items_sent <= items_sent + 1;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : input_capture
		fraction_pair_t taken;
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				taken.op = operation;
				taken.a = first_numerator;
				taken.b = first_denominator;
				taken.c = second_numerator;
				taken.d = second_denominator;
				taken.drain_before = 1'b0;
				expected_fractions.push_back(reduced_sum(taken));
				items_accepted <= items_accepted + 1;
			end
		end
	end

	// receiver: random stalls, one long hold-off, one quiet window
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!hold_done && fractions_seen >= 150) begin
			out_stall <= 1'b1;
			hold_left <= 600;
			hold_done <= 1'b1;
		end else if (fractions_seen >= 300 && fractions_seen < 450) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < 11);
		end
	end

	// monitor
	always @(posedge clk) begin : monitor
		reduced_fraction_t want;
		if (arst_n && out_valid && !out_stall) begin
			fractions_seen <= fractions_seen + 1;
			if (expected_fractions.size() == 0) begin
				report_mismatch("unexpected transaction, numerator",
				                longint'(result_numerator), longint'(0));
			end else begin
				want = expected_fractions.pop_front();
				if (result_numerator !== want.num)
					report_mismatch("result_numerator", longint'(result_numerator),
					                longint'(want.num));
				if (result_denominator !== want.den)
					report_mismatch("result_denominator", longint'(result_denominator),
					                longint'(want.den));
				if (result_status !== want.status)
					report_mismatch("result_status", longint'(result_status),
					                longint'(want.status));
			end
		end
	end

	initial begin : stimulus
		fraction_pair_t p;
		logic signed [OPERAND_WIDTH-1:0] corner_values[5];
		int kind;
		corner_values = '{16'sh8000, 16'shffff, 16'sh0000, 16'sh0001, 16'sh7fff};

		add_pair(OP_ADD, 1, 2, 1, 3);
		add_pair(OP_SUB, 1, 2, 1, 3);
		add_pair(OP_ADD, 32767, 32767, 32767, 32767);
		add_pair(OP_ADD, -32768, -32768, -32768, -32768);
		add_pair(OP_SUB, -32768, -32767, 32767, -32768);
		add_pair(OP_ADD, 32767, -32768, -32768, 32767);
		add_pair(OP_SUB, 32767, -32768, -32768, 32767);
		add_pair(OP_ADD, 5, 0, 3, 7);
		add_pair(OP_SUB, 5, 7, 3, 0);
		add_pair(OP_ADD, 0, 0, 0, 0);
		add_pair(OP_ADD, 0, 5, 0, -9);
		add_pair(OP_SUB, 7, 11, 7, 11);
		add_pair(OP_ADD, -3, 4, 3, 4);
		add_pair(OP_ADD, 1, -2, 1, 3);
		add_pair(OP_SUB, -1, 2, 1, 3);
		add_pair(OP_ADD, -32768, 1, -32768, 1);
		add_pair(OP_SUB, -32768, -1, 32767, 1);
		add_pair(OP_ADD, 6, 4, 9, 6);
		add_pair(OP_SUB, 1, -1, -1, -1);
		add_pair(OP_ADD, -32768, 32767, 0, 1);

		for (int i = 0; i < 800; i++) begin
			kind = $urandom_range(0, 9);
			p.op = 1'($urandom_range(0, 1));
			p.a = OPERAND_WIDTH'($urandom);
			p.b = OPERAND_WIDTH'($urandom);
			p.c = OPERAND_WIDTH'($urandom);
			p.d = OPERAND_WIDTH'($urandom);
			p.drain_before = (i == 480 || i == 640);
			case (kind)
				4, 5, 6: begin
					p.a = OPERAND_WIDTH'($urandom_range(0, 100) - 50);
					p.b = OPERAND_WIDTH'($urandom_range(0, 100) - 50);
					p.c = OPERAND_WIDTH'($urandom_range(0, 100) - 50);
					p.d = OPERAND_WIDTH'($urandom_range(0, 100) - 50);
				end
				7: begin
					if ($urandom_range(0, 1))
						p.b = '0;
					else
						p.d = '0;
				end
				8: begin
					p.op = OP_SUB;
					p.c = p.a;
					p.d = p.b;
				end
				9: begin
					p.a = corner_values[$urandom_range(0, 4)];
					p.b = corner_values[$urandom_range(0, 4)];
					p.c = corner_values[$urandom_range(0, 4)];
					p.d = corner_values[$urandom_range(0, 4)];
				end
				default: begin
				end
			endcase
			pending_pairs.push_back(p);
		end
		total_items = pending_pairs.size();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (items_accepted != total_items || expected_fractions.size() != 0)
			@(negedge clk);
		repeat (200) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
